### src/msda_pkg.sv
package msda_pkg;

    // Field and register widths.
    localparam int DATA_W  = 32;
    localparam int COEF_W  = 31;
    localparam int STEP_W  = 24;
    localparam int ADDR_W  = 3;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = 50;

    // Fraction shifts of the products.
    localparam int COEF_FRAC = 16;
    localparam int STEP_FRAC = 24;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_DAMPING   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_STIFFNESS = 3'd1;
    localparam logic [ADDR_W-1:0] REG_INV_MASS  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_TIME_STEP = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LIMIT     = 3'd4;

    // Reset value of the position limit (0.2 in Q16.16).
    localparam logic [COEF_W-1:0] LIMIT_RESET = 31'd13107;

    // Request actions.
    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]  wide_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic sample_t sat32(input wide_t x);
        wide_t max_v;
        wide_t min_v;
        max_v = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
        min_v = -max_v - wide_t'(1);
        if (x > max_v) begin
            return sample_t'(max_v);
        end else if (x < min_v) begin
            return sample_t'(min_v);
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

### src/mass_spring_damper_admittance.sv
// One axis of a mass-spring-damper admittance controller in Q16.16 fixed point.
// Write the coefficient registers through cfg_we/cfg_addr/cfg_wdata while the
// block is idle, then send one request per control period: a step request
// advances velocity and position offset by one forward-Euler step, clamps the
// offset to the position limit and returns reference minus offset; a clear
// request zeroes the state and returns the reference. A step request goes
// through the acceptance state, five passes through the single shared 32x32
// multiplier and a write-back state; a clear request goes from acceptance
// straight to write-back. The write-back stalls while a held result waits
// for m_tready. The next request is accepted as soon as its predecessor's
// result has been written to the output register, even while that result
// waits for m_tready.
module mass_spring_damper_admittance (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [msda_pkg::ADDR_W-1:0]         cfg_addr,
    input  logic [msda_pkg::COEF_W-1:0]         cfg_wdata,
    // Request channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*msda_pkg::DATA_W-1:0]       s_tdata,  // reference, force_req
    input  logic                                s_tuser,  // action
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msda_pkg::DATA_W-1:0]         m_tdata,  // command
    output logic                                m_tuser   // clamped
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MD   = 3'd1;
    localparam logic [2:0] ST_MK   = 3'd2;
    localparam logic [2:0] ST_MF   = 3'd3;
    localparam logic [2:0] ST_MV   = 3'd4;
    localparam logic [2:0] ST_MA   = 3'd5;
    localparam logic [2:0] ST_UV   = 3'd6;

    localparam int DW = msda_pkg::DATA_W;
    localparam int PW = msda_pkg::PROD_W;
    localparam int CF = msda_pkg::COEF_FRAC;
    localparam int SF = msda_pkg::STEP_FRAC;

    // Configuration registers.
    logic [msda_pkg::COEF_W-1:0] damp_reg, stiff_reg, inv_mass_reg, limit_reg;
    logic [msda_pkg::STEP_W-1:0] dt_reg;

    // Sequencer and datapath registers.
    logic [2:0]          state_reg, state_next;
    msda_pkg::sample_t   vel_reg, vel_next;
    msda_pkg::sample_t   pos_reg, pos_next;
    msda_pkg::sample_t   ref_reg, ref_next;
    msda_pkg::sample_t   force_reg, force_next;
    logic                clear_reg, clear_next;
    logic                hit_reg, hit_next;
    logic signed [PW-1:0] mul_reg, mul_next;
    msda_pkg::wide_t     acc_reg, acc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    msda_pkg::sample_t   cmd_reg, cmd_next;
    logic                clamp_out_reg, clamp_out_next;

    // Shared multiplier operands.
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] product;

    // Helper terms.
    msda_pkg::wide_t      coef_term;
    msda_pkg::wide_t      step_term;
    msda_pkg::sample_t    accel;
    msda_pkg::sample_t    pos_sat;
    logic signed [DW:0]   lim_pos, pos_ext;
    logic signed [DW-1:0] dt_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cmd_reg;
    assign m_tuser  = clamp_out_reg;

    // Product slices are sign-extended so that the shifts round toward minus infinity.
    assign dt_ext    = $signed({{(DW-msda_pkg::STEP_W){1'b0}}, dt_reg});
    assign coef_term = msda_pkg::wide_t'($signed(mul_reg[PW-1:CF]));
    assign step_term = msda_pkg::wide_t'($signed(mul_reg[PW-1:SF]));
    assign accel     = msda_pkg::sat32(acc_reg);
    assign pos_sat   = msda_pkg::sat32(msda_pkg::wide_t'(pos_reg) + step_term);
    assign lim_pos   = $signed({2'b00, limit_reg});
    assign pos_ext   = (DW+1)'(pos_sat);

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = vel_reg;
        op_b = dt_ext;
        unique case (state_reg)
            ST_MD:   begin op_a = $signed({1'b0, damp_reg});     op_b = vel_reg;   end
            ST_MK:   begin op_a = $signed({1'b0, stiff_reg});    op_b = pos_reg;   end
            ST_MF:   begin op_a = $signed({1'b0, inv_mass_reg}); op_b = force_reg; end
            ST_MV:   begin op_a = vel_reg;                       op_b = dt_ext;    end
            ST_MA:   begin op_a = accel;                         op_b = dt_ext;    end
            default: begin op_a = vel_reg;                       op_b = dt_ext;    end
        endcase
    end

    assign product = op_a * op_b;

    // Sequencer: one multiply in each state from ST_MD to ST_MA; each later state uses the previous product.
    always_comb begin
        state_next     = state_reg;
        vel_next       = vel_reg;
        pos_next       = pos_reg;
        ref_next       = ref_reg;
        force_next     = force_reg;
        clear_next     = clear_reg;
        hit_next       = hit_reg;
        mul_next       = mul_reg;
        acc_next       = acc_reg;
        cmd_next       = cmd_reg;
        clamp_out_next = clamp_out_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ref_next   = s_tdata[DW-1:0];
                    force_next = s_tdata[2*DW-1:DW];
                    clear_next = s_tuser;
                    hit_next   = 1'b0;
                    if (s_tuser == msda_pkg::ACT_CLEAR) begin
                        pos_next   = '0;
                        state_next = ST_UV;
                    end else begin
                        state_next = ST_MD;
                    end
                end
            end
            ST_MD: begin
                mul_next   = product;
                state_next = ST_MK;
            end
            ST_MK: begin
                mul_next   = product;
                acc_next   = -coef_term;
                state_next = ST_MF;
            end
            ST_MF: begin
                mul_next   = product;
                acc_next   = acc_reg - coef_term;
                state_next = ST_MV;
            end
            ST_MV: begin
                mul_next   = product;
                acc_next   = acc_reg + coef_term;
                state_next = ST_MA;
            end
            ST_MA: begin
                // Position update from the old velocity, then clamp.
                mul_next = product;
                pos_next = pos_sat;
                if (pos_ext > lim_pos) begin
                    pos_next = lim_pos[DW-1:0];
                    hit_next = 1'b1;
                end else if (pos_ext < -lim_pos) begin
                    pos_next = DW'(-lim_pos);
                    hit_next = 1'b1;
                end
                state_next = ST_UV;
            end
            ST_UV: begin
                // Write back velocity and the result once the output slot is free.
                if (!m_tvalid_reg || m_tready) begin
                    if (clear_reg == msda_pkg::ACT_CLEAR) begin
                        vel_next = '0;
                    end else begin
                        vel_next = msda_pkg::sat32(msda_pkg::wide_t'(vel_reg) + step_term);
                    end
                    cmd_next       = msda_pkg::sat32(msda_pkg::wide_t'(ref_reg)
                                                     - msda_pkg::wide_t'(pos_reg));
                    clamp_out_next = hit_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            vel_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            vel_reg      <= vel_next;
            pos_reg      <= pos_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ref_reg       <= ref_next;
        force_reg     <= force_next;
        clear_reg     <= clear_next;
        hit_reg       <= hit_next;
        mul_reg       <= mul_next;
        acc_reg       <= acc_next;
        cmd_reg       <= cmd_next;
        clamp_out_reg <= clamp_out_next;
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg     <= '0;
            stiff_reg    <= '0;
            inv_mass_reg <= '0;
            dt_reg       <= '0;
            limit_reg    <= msda_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                msda_pkg::REG_DAMPING:   damp_reg     <= cfg_wdata;
                msda_pkg::REG_STIFFNESS: stiff_reg    <= cfg_wdata;
                msda_pkg::REG_INV_MASS:  inv_mass_reg <= cfg_wdata;
                msda_pkg::REG_TIME_STEP: dt_reg       <= cfg_wdata[msda_pkg::STEP_W-1:0];
                msda_pkg::REG_LIMIT:     limit_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

### src/msda_checker.sv
module msda_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [msda_pkg::DATA_W-1:0]   m_tdata,
    input logic                          m_tuser
);

    // An accepted request makes the block busy, so s_tready drops once a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // A new result appears exactly when the block returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result appeared while busy");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mass_spring_damper_admittance msda_checker u_msda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE_A    = 2;
    localparam int HOLD_PHASE_B    = 8;
    localparam int REPORT_LIMIT    = 25;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [msda_pkg::ADDR_W-1:0] REG_UNMAPPED = 3'd6;
    localparam logic [msda_pkg::COEF_W-1:0] COEF_MAX     = {msda_pkg::COEF_W{1'b1}};

    localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [msda_pkg::DATA_W-1:0] command;
        logic                        clamped;
    } step_result_t;

    // Tracks the controller state and the queue of commands still owed.
    class admittance_scoreboard;
        logic [msda_pkg::COEF_W-1:0] damping;
        logic [msda_pkg::COEF_W-1:0] stiffness;
        logic [msda_pkg::COEF_W-1:0] inv_mass;
        logic [msda_pkg::COEF_W-1:0] limit;
        logic [msda_pkg::STEP_W-1:0] step_len;
        int                velocity;
        int                offset;
        step_result_t      expected_q[$];
        int                errors;
        int                checked;
        int                clamps;
        int                clears;

        function new();
            damping   = '0;
            stiffness = '0;
            inv_mass  = '0;
            step_len  = '0;
            limit     = msda_pkg::LIMIT_RESET;
            velocity  = 0;
            offset    = 0;
            errors    = 0;
            checked   = 0;
            clamps    = 0;
            clears    = 0;
        endfunction

        function int clip_word(longint x);
            if (x > WORD_MAX) begin
                return int'(WORD_MAX);
            end else if (x < WORD_MIN) begin
                return int'(WORD_MIN);
            end
            return int'(x);
        endfunction

        function void set_register(logic [msda_pkg::ADDR_W-1:0] idx,
                                   logic [msda_pkg::COEF_W-1:0] value);
            case (idx)
                msda_pkg::REG_DAMPING:   damping   = value;
                msda_pkg::REG_STIFFNESS: stiffness = value;
                msda_pkg::REG_INV_MASS:  inv_mass  = value;
                msda_pkg::REG_TIME_STEP: step_len  = value[msda_pkg::STEP_W-1:0];
                msda_pkg::REG_LIMIT:     limit     = value;
                default: ;
            endcase
        endfunction

        // One forward-Euler step of the virtual mass-spring-damper per step request; a clear request zeroes the state.
        function void note_request(logic act, logic [msda_pkg::DATA_W-1:0] ref_raw,
                                   logic [msda_pkg::DATA_W-1:0] force_raw);
            longint v;
            longint p;
            longint accel;
            longint next_p;
            step_result_t r;
            r.clamped = 1'b0;
            if (act == msda_pkg::ACT_CLEAR) begin
                velocity = 0;
                offset   = 0;
                clears++;
            end else begin
                v = velocity;
                p = offset;
                accel = clip_word(
                    ((longint'(inv_mass) * longint'($signed(force_raw)))
                        >>> msda_pkg::COEF_FRAC)
                    - ((longint'(damping) * v) >>> msda_pkg::COEF_FRAC)
                    - ((longint'(stiffness) * p) >>> msda_pkg::COEF_FRAC));
                velocity = clip_word(v + ((accel * longint'(step_len))
                                          >>> msda_pkg::STEP_FRAC));
                next_p = clip_word(p + ((v * longint'(step_len)) >>> msda_pkg::STEP_FRAC));
                // A position sitting exactly on the limit is not a clamp.
                if (next_p > longint'(limit)) begin
                    next_p = longint'(limit);
                    r.clamped = 1'b1;
                end else if (next_p < -longint'(limit)) begin
                    next_p = -longint'(limit);
                    r.clamped = 1'b1;
                end
                offset = int'(next_p);
                if (r.clamped) begin
                    clamps++;
                end
            end
            r.command = clip_word(longint'($signed(ref_raw)) - longint'(offset));
            expected_q.push_back(r);
        endfunction

        task flag_mismatch(string what);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("tb: mismatch: %s", what);
            end
        endtask

        task check_result(logic [msda_pkg::DATA_W-1:0] command, logic clamped);
            step_result_t want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("result with no request pending, command %h", command));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (command !== want.command) begin
                flag_mismatch($sformatf("result %0d command %h, predicted %h",
                                        checked, command, want.command));
            end
            if (clamped !== want.clamped) begin
                flag_mismatch($sformatf("result %0d clamped %b, predicted %b",
                                        checked, clamped, want.clamped));
            end
        endtask
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [msda_pkg::ADDR_W-1:0]     cfg_addr  = '0;
    logic [msda_pkg::COEF_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [2*msda_pkg::DATA_W-1:0]   s_tdata   = '0;  // reference, force_req
    logic                            s_tuser   = 1'b0;  // action
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [msda_pkg::DATA_W-1:0]     m_tdata;  // command
    logic                            m_tuser;  // clamped

    admittance_scoreboard sb;
    int unsigned send_idle_pct   = 7;
    int unsigned recv_idle_pct   = 82;
    int          hold_asked      = 0;
    int          hold_granted    = 0;
    int          hold_left       = 0;
    int          settings_loaded = 0;
    int unsigned cycle_count     = 0;

    mass_spring_damper_admittance uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_granted) begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_OFF_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watch both handshakes and keep the prediction in step with the block.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata[msda_pkg::DATA_W-1:0],
                                s_tdata[2*msda_pkg::DATA_W-1:msda_pkg::DATA_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, until accepted.
    task automatic send_request(input logic act,
                                input logic [msda_pkg::DATA_W-1:0] ref_pos,
                                input logic [msda_pkg::DATA_W-1:0] frc);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {frc, ref_pos};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_register(input logic [msda_pkg::ADDR_W-1:0] idx,
                                input logic [msda_pkg::COEF_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic load_settings(input logic [msda_pkg::COEF_W-1:0] damping,
                                 input logic [msda_pkg::COEF_W-1:0] stiffness,
                                 input logic [msda_pkg::COEF_W-1:0] inv_mass,
                                 input logic [msda_pkg::COEF_W-1:0] step_word,
                                 input logic [msda_pkg::COEF_W-1:0] limit);
        put_register(msda_pkg::REG_DAMPING, damping);
        put_register(msda_pkg::REG_STIFFNESS, stiffness);
        put_register(msda_pkg::REG_INV_MASS, inv_mass);
        put_register(msda_pkg::REG_TIME_STEP, step_word);
        put_register(msda_pkg::REG_LIMIT, limit);
        put_register(REG_UNMAPPED, msda_pkg::COEF_W'($urandom()));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [msda_pkg::COEF_W-1:0] pick_limit();
        case ($urandom_range(3))
            0: return msda_pkg::LIMIT_RESET;
            1: return msda_pkg::COEF_W'($urandom_range(1, 1 << 18));
            2: return msda_pkg::COEF_W'($urandom());
            default: return msda_pkg::COEF_W'($urandom_range(0, 64));
        endcase
    endfunction

    initial begin
        logic                        act;
        logic [msda_pkg::DATA_W-1:0] ref_pos;
        logic [msda_pkg::DATA_W-1:0] frc;
        int                          force_log;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero time step, so the command follows the reference.
        send_request(msda_pkg::ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(msda_pkg::ACT_STEP, 32'h8000_0000, 32'h8000_0000);
        send_request(msda_pkg::ACT_STEP, 32'h0000_0000, $urandom());
        send_request(msda_pkg::ACT_CLEAR, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_for_results();

        // Unit mass and half-second steps walk the offset onto the limit exactly,
        // then one step past it; the same on the negative side.
        load_settings('0, '0, msda_pkg::COEF_W'(1 << msda_pkg::COEF_FRAC),
                      msda_pkg::COEF_W'(1 << 23), msda_pkg::COEF_W'(4096));
        send_request(msda_pkg::ACT_CLEAR, 32'h0001_0000, 32'h0);
        send_request(msda_pkg::ACT_STEP, 32'h0001_0000, 32'h0000_4000);
        send_request(msda_pkg::ACT_STEP, 32'h0001_0000, 32'h0);
        send_request(msda_pkg::ACT_STEP, 32'h0001_0000, 32'h0);
        send_request(msda_pkg::ACT_CLEAR, 32'hFFFF_0000, 32'h0);
        send_request(msda_pkg::ACT_STEP, 32'hFFFF_0000, 32'hFFFF_C000);
        send_request(msda_pkg::ACT_STEP, 32'hFFFF_0000, 32'h0);
        send_request(msda_pkg::ACT_STEP, 32'hFFFF_0000, 32'h0);
        wait_for_results();

        // Full-scale mass and step: velocity, offset and command all saturate.
        load_settings('0, '0, COEF_MAX, COEF_MAX, COEF_MAX);
        send_request(msda_pkg::ACT_CLEAR, 32'h0, 32'h0);
        repeat (3) send_request(msda_pkg::ACT_STEP, 32'h0, 32'h7FFF_FFFF);
        send_request(msda_pkg::ACT_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        repeat (3) send_request(msda_pkg::ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_for_results();

        // Random phases; each phase loads its coefficients before its requests.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 6) begin
                send_idle_pct = 82;
                recv_idle_pct <= 7;
            end else if (phase == 11) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            case (phase % 8)
                3: load_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                5: load_settings('0, '0, '0, {7'($urandom()), 24'd0}, pick_limit());
                6: load_settings(msda_pkg::COEF_W'($urandom_range(0, 40 << 16)),
                                 msda_pkg::COEF_W'($urandom_range(0, 400 << 16)),
                                 msda_pkg::COEF_W'($urandom_range(0, 8 << 16)),
                                 {7'($urandom()), 24'($urandom_range(0, 1 << 20))}, '0);
                default: load_settings(msda_pkg::COEF_W'($urandom_range(0, 40 << 16)),
                                       msda_pkg::COEF_W'($urandom_range(0, 400 << 16)),
                                       msda_pkg::COEF_W'($urandom_range(0, 8 << 16)),
                                       {7'($urandom()),
                                        24'($urandom_range(0, 1 << $urandom_range(10, 22)))},
                                       pick_limit());
            endcase
            force_log = $urandom_range(12, 22);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the result side off while requests keep coming.
                if ((phase == HOLD_PHASE_A || phase == HOLD_PHASE_B) && n == 10) begin
                    hold_asked <= hold_asked + 1;
                end
                act = ($urandom_range(99) < 4) ? msda_pkg::ACT_CLEAR : msda_pkg::ACT_STEP;
                frc = ($urandom_range(99) < 15) ? $urandom()
                    : msda_pkg::DATA_W'(int'($urandom_range(0, 2 << force_log))
                                        - (1 << force_log));
                ref_pos = ($urandom_range(99) < 15) ? $urandom()
                        : msda_pkg::DATA_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
                send_request(act, ref_pos, frc);
            end
            wait_for_results();
        end

        $display("tb: %0d commands checked over %0d coefficient settings",
                 sb.checked, settings_loaded);
        $display("tb: %0d clear requests, %0d clamped steps, %0d mismatches",
                 sb.clears, sb.clamps, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
src/msda_pkg.sv
src/mass_spring_damper_admittance.sv
src/msda_checker.sv
dv/tb.sv
